### src/tw_slip_pkg.sv
// Shared types and constants for the three-wire UART SLIP deframer.
package tw_slip_pkg;

   localparam int unsigned LIMIT_W = 12;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] ESC_BYTE     = 8'hDB;
   localparam logic [7:0] ESC_CODE_END = 8'hDC;
   localparam logic [7:0] ESC_CODE_ESC = 8'hDD;

   localparam logic [LIMIT_W-1:0] DATA_LIMIT_RESET = 12'd1024;
   localparam logic [LIMIT_W-1:0] LINK_LIMIT_RESET = 12'd3;

   localparam logic [3:0] TYPE_ACK  = 4'h0;
   localparam logic [3:0] TYPE_CMD  = 4'h1;
   localparam logic [3:0] TYPE_ACL  = 4'h2;
   localparam logic [3:0] TYPE_EVT  = 4'h4;
   localparam logic [3:0] TYPE_ISO  = 4'h5;
   localparam logic [3:0] TYPE_LINK = 4'hF;

   typedef enum logic [0:0] {
      CSR_DATA_LIMIT = 1'b0,
      CSR_LINK_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_END     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_DROP = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      DEST_DISCARD = 2'd0,
      DEST_LINK    = 2'd1,
      DEST_HOST    = 2'd2
   } dest_type;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_ESCAPE   = 3'd1,
      ERR_EARLY    = 3'd2,
      ERR_OVERFLOW = 3'd3,
      ERR_NO_END   = 3'd4,
      ERR_SEQUENCE = 3'd5
   } err_type;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      logic [3:0]         pkt_type;
      logic               reliable;
      logic [2:0]         seq_num;
      logic [2:0]         peer_ack;
      logic [LIMIT_W-1:0] payload_len;
      dest_type           destination;
      logic               send_ack;
      err_type            error_code;
      logic [2:0]         next_expected_seq;
   } rsp_type;

   function automatic logic type_reliable(input logic [3:0] t);
      return (t == TYPE_CMD) || (t == TYPE_ACL) || (t == TYPE_EVT) || (t == TYPE_ISO);
   endfunction

   function automatic logic type_data(input logic [3:0] t);
      return (t == TYPE_CMD) || (t == TYPE_ACL) || (t == TYPE_ISO);
   endfunction

endpackage

### src/three_wire_uart_slip_deframer_core.sv
// Three-wire UART receive deframer: SLIP unescape, header parse, payload pass-through.
//
// Usage:
//   req channel carries one UART byte per transfer (func = 0) or a link resync
//   command (func = 1) that clears the sequence counters and the parser.
//   rsp channel carries at most one result per input transfer: a payload byte,
//   a packet-complete report with type and routing, or a drop with error code.
//   csr port writes the two payload limits (index 0 data, index 1 link); write
//   them only while no transfer is in flight.
// Timing and throughput:
//   A byte is parsed in the cycle it is accepted; its result is on rsp in the
//   next cycle. One byte can be accepted every cycle when not stalled; the parse
//   is one pass of byte-wide compares, one 12-bit limit compare and decrement.
// Stall behavior:
//   The result register acts as the only buffer. While it holds a result and the
//   receiver stalls, req_stall is raised and the parser state holds; a result
//   taken in the same cycle frees the slot for the next byte at once.
// Reset:
//   Synchronous, active high. The parser hunts for a start delimiter, sequence
//   and counters clear, and the limits return to 1024 (data) and 3 (link).
module three_wire_uart_slip_deframer_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tw_slip_pkg::req_type   req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tw_slip_pkg::rsp_type   rsp_data,
   input  logic                   csr_write,
   input  tw_slip_pkg::csr_index_type csr_index,
   input  logic [tw_slip_pkg::LIMIT_W-1:0] csr_wdata
);

   localparam int unsigned LW = tw_slip_pkg::LIMIT_W;

   // Configuration registers
   logic [LW-1:0] data_limit_ff;
   logic [LW-1:0] link_limit_ff;

   // Parser state
   tw_slip_pkg::phase_type phase_ff, phase_in;
   logic                   esc_ff, esc_in;
   logic [1:0]             hcount_ff, hcount_in;
   logic [7:0]             hdr_ff [3];
   logic [7:0]             hdr_in [3];
   logic [LW-1:0]          left_ff, left_in;
   logic [LW-1:0]          pcount_ff, pcount_in;
   logic [2:0]             exp_seq_ff, exp_seq_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   tw_slip_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   res_valid;

   // Stall only when the result slot is full and not being drained.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_limit_ff <= tw_slip_pkg::DATA_LIMIT_RESET;
         link_limit_ff <= tw_slip_pkg::LINK_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tw_slip_pkg::CSR_DATA_LIMIT: data_limit_ff <= csr_wdata;
            tw_slip_pkg::CSR_LINK_LIMIT: link_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin : parse_step
      logic [7:0]             b;
      logic                   go;
      logic                   drop;
      logic                   drop_hdr;
      tw_slip_pkg::err_type   drop_code;
      logic [3:0]             t;
      logic [3:0]             new_t;
      logic [LW-1:0]          new_len;
      logic [LW-1:0]          limit;

      phase_in    = phase_ff;
      esc_in      = esc_ff;
      hcount_in   = hcount_ff;
      hdr_in      = hdr_ff;
      left_in     = left_ff;
      pcount_in   = pcount_ff;
      exp_seq_in  = exp_seq_ff;
      res_valid   = 1'b0;
      rsp_data_in = '0;

      b         = req_data.rx_byte;
      go        = 1'b0;
      drop      = 1'b0;
      drop_hdr  = 1'b0;
      drop_code = tw_slip_pkg::ERR_NONE;
      t         = hdr_ff[1][3:0];
      new_t     = hdr_ff[1][3:0];
      new_len   = {hdr_ff[2], hdr_ff[1][7:4]};
      limit     = tw_slip_pkg::type_data(t) ? data_limit_ff : link_limit_ff;

      if (accept) begin
         if (req_data.func) begin
            // Resync: clear parser and sequence, no result.
            phase_in   = tw_slip_pkg::PH_HUNT;
            esc_in     = 1'b0;
            hcount_in  = '0;
            left_in    = '0;
            pcount_in  = '0;
            exp_seq_in = '0;
         end else begin
            case (phase_ff)
               tw_slip_pkg::PH_HUNT: begin
                  if (b == tw_slip_pkg::SLIP_END) begin
                     phase_in  = tw_slip_pkg::PH_HEADER;
                     esc_in    = 1'b0;
                     hcount_in = '0;
                     left_in   = '0;
                     pcount_in = '0;
                  end
               end
               tw_slip_pkg::PH_END: begin
                  if (b != tw_slip_pkg::SLIP_END) begin
                     drop      = 1'b1;
                     drop_hdr  = 1'b1;
                     drop_code = tw_slip_pkg::ERR_NO_END;
                  end else if (hdr_ff[0][7] && (hdr_ff[0][2:0] != exp_seq_ff)) begin
                     drop      = 1'b1;
                     drop_hdr  = 1'b1;
                     drop_code = tw_slip_pkg::ERR_SEQUENCE;
                  end else begin
                     // Packet complete: advance expected sequence for reliable types.
                     if (tw_slip_pkg::type_reliable(t)) begin
                        exp_seq_in = exp_seq_ff + 3'd1;
                     end
                     res_valid               = 1'b1;
                     rsp_data_in.kind        = tw_slip_pkg::KIND_DONE;
                     rsp_data_in.pkt_type    = t;
                     rsp_data_in.reliable    = hdr_ff[0][7];
                     rsp_data_in.seq_num     = hdr_ff[0][2:0];
                     rsp_data_in.peer_ack    = hdr_ff[0][5:3];
                     rsp_data_in.payload_len = {hdr_ff[2], hdr_ff[1][7:4]};
                     if (t == tw_slip_pkg::TYPE_LINK) begin
                        rsp_data_in.destination = tw_slip_pkg::DEST_LINK;
                     end else if (tw_slip_pkg::type_data(t)) begin
                        rsp_data_in.destination = tw_slip_pkg::DEST_HOST;
                     end else begin
                        rsp_data_in.destination = tw_slip_pkg::DEST_DISCARD;
                     end
                     rsp_data_in.send_ack = tw_slip_pkg::type_reliable(t);
                     phase_in  = tw_slip_pkg::PH_HUNT;
                     esc_in    = 1'b0;
                     hcount_in = '0;
                     left_in   = '0;
                     pcount_in = '0;
                  end
               end
               default: begin
                  // Header or payload: undo SLIP escapes first.
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     if (b == tw_slip_pkg::ESC_CODE_END) begin
                        b  = tw_slip_pkg::SLIP_END;
                        go = 1'b1;
                     end else if (b == tw_slip_pkg::ESC_CODE_ESC) begin
                        b  = tw_slip_pkg::ESC_BYTE;
                        go = 1'b1;
                     end else begin
                        drop      = 1'b1;
                        drop_hdr  = (phase_ff == tw_slip_pkg::PH_PAYLOAD);
                        drop_code = tw_slip_pkg::ERR_ESCAPE;
                     end
                  end else if (b == tw_slip_pkg::SLIP_END) begin
                     if (phase_ff == tw_slip_pkg::PH_HEADER) begin
                        hcount_in = '0;
                     end else begin
                        drop      = 1'b1;
                        drop_hdr  = 1'b1;
                        drop_code = tw_slip_pkg::ERR_EARLY;
                     end
                  end else if (b == tw_slip_pkg::ESC_BYTE) begin
                     esc_in = 1'b1;
                  end else begin
                     go = 1'b1;
                  end

                  if (go && (phase_ff == tw_slip_pkg::PH_HEADER)) begin
                     if (hcount_ff != 2'd3) begin
                        hdr_in[hcount_ff] = b;
                        hcount_in         = hcount_ff + 2'd1;
                     end else begin
                        // Fourth byte is the header checksum: consume it and decide.
                        hcount_in = '0;
                        new_t     = hdr_ff[1][3:0];
                        new_len   = {hdr_ff[2], hdr_ff[1][7:4]};
                        left_in   = new_len;
                        pcount_in = '0;
                        if ((tw_slip_pkg::type_data(new_t) || (new_t == tw_slip_pkg::TYPE_ACK)
                             || (new_t == tw_slip_pkg::TYPE_LINK)) && (new_len != '0)) begin
                           phase_in = tw_slip_pkg::PH_PAYLOAD;
                        end else begin
                           phase_in = tw_slip_pkg::PH_END;
                        end
                     end
                  end else if (go) begin
                     if (pcount_ff >= limit) begin
                        drop      = 1'b1;
                        drop_hdr  = 1'b1;
                        drop_code = tw_slip_pkg::ERR_OVERFLOW;
                     end else begin
                        pcount_in = pcount_ff + 1'b1;
                        left_in   = left_ff - 1'b1;
                        if (left_ff == {{(LW-1){1'b0}}, 1'b1}) begin
                           phase_in = tw_slip_pkg::PH_END;
                        end
                        res_valid             = 1'b1;
                        rsp_data_in.kind      = tw_slip_pkg::KIND_DATA;
                        rsp_data_in.data_byte = b;
                     end
                  end
               end
            endcase

            if (drop) begin
               // Drop the packet and go back to hunting; the failing byte is not reused.
               phase_in               = tw_slip_pkg::PH_HUNT;
               esc_in                 = 1'b0;
               hcount_in              = '0;
               left_in                = '0;
               pcount_in              = '0;
               res_valid              = 1'b1;
               rsp_data_in            = '0;
               rsp_data_in.kind       = tw_slip_pkg::KIND_DROP;
               rsp_data_in.error_code = drop_code;
               if (drop_hdr) begin
                  rsp_data_in.pkt_type    = t;
                  rsp_data_in.reliable    = hdr_ff[0][7];
                  rsp_data_in.seq_num     = hdr_ff[0][2:0];
                  rsp_data_in.peer_ack    = hdr_ff[0][5:3];
                  rsp_data_in.payload_len = {hdr_ff[2], hdr_ff[1][7:4]};
               end
            end
         end
      end

      rsp_data_in.next_expected_seq = exp_seq_in;
   end

   // Result slot fills on an accepted byte with a result, empties when taken.
   assign rsp_valid_in = accept ? res_valid : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= tw_slip_pkg::PH_HUNT;
         esc_ff       <= 1'b0;
         hcount_ff    <= '0;
         left_ff      <= '0;
         pcount_ff    <= '0;
         exp_seq_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         esc_ff       <= esc_in;
         hcount_ff    <= hcount_in;
         left_ff      <= left_in;
         pcount_ff    <= pcount_in;
         exp_seq_ff   <= exp_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: header bytes and result data need no reset.
   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
      if (accept && res_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### sim/deframer_checker.sv
`timescale 1ns / 100ps
// Result checker for the SLIP deframer: predicts each result transfer and compares it.
module deframer_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  tw_slip_pkg::req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  tw_slip_pkg::rsp_type            rsp_data,
   input  logic                            csr_write,
   input  tw_slip_pkg::csr_index_type      csr_index,
   input  logic [tw_slip_pkg::LIMIT_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              results_pending,
   output logic [2:0]                      seq_now
);

   localparam int unsigned LW = tw_slip_pkg::LIMIT_W;

   tw_slip_pkg::phase_type parse_phase;
   logic                   escape_armed;
   logic [2:0]             header_idx;
   logic [7:0]             header_store [3];
   logic [LW-1:0]          remaining;
   logic [LW-1:0]          emitted;
   logic [2:0]             rx_expected_seq;
   logic [LW-1:0]          data_limit;
   logic [LW-1:0]          link_limit;
   tw_slip_pkg::rsp_type   expected_results [$];

   initial begin
      fail_count = 0;
      results_pending = 0;
      rx_expected_seq = '0;
   end

   assign seq_now = rx_expected_seq;

   function automatic tw_slip_pkg::dest_type route_for(input logic [3:0] t);
      case (t)
         tw_slip_pkg::TYPE_LINK: return tw_slip_pkg::DEST_LINK;
         tw_slip_pkg::TYPE_CMD, tw_slip_pkg::TYPE_ACL, tw_slip_pkg::TYPE_ISO:
            return tw_slip_pkg::DEST_HOST;
         default: return tw_slip_pkg::DEST_DISCARD;
      endcase
   endfunction

   function automatic logic needs_ack(input logic [3:0] t);
      case (t)
         tw_slip_pkg::TYPE_CMD, tw_slip_pkg::TYPE_ACL, tw_slip_pkg::TYPE_EVT,
         tw_slip_pkg::TYPE_ISO: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic tw_slip_pkg::rsp_type with_header(input tw_slip_pkg::rsp_type r);
      r.pkt_type    = header_store[1][3:0];
      r.reliable    = header_store[0][7];
      r.seq_num     = header_store[0][2:0];
      r.peer_ack    = header_store[0][5:3];
      r.payload_len = {header_store[2], header_store[1][7:4]};
      return r;
   endfunction

   task automatic reset_parser();
      parse_phase  = tw_slip_pkg::PH_HUNT;
      escape_armed = 1'b0;
      header_idx   = '0;
      remaining    = '0;
      emitted      = '0;
   endtask

   task automatic drop_packet(input tw_slip_pkg::err_type code, input logic keep_header);
      tw_slip_pkg::rsp_type res;
      res = '0;
      res.kind = tw_slip_pkg::KIND_DROP;
      if (keep_header)
         res = with_header(res);
      res.error_code = code;
      res.next_expected_seq = rx_expected_seq;
      expected_results.push_back(res);
      reset_parser();
   endtask

   task automatic deframe_byte(input tw_slip_pkg::req_type item);
      tw_slip_pkg::rsp_type res;
      logic [7:0]           b;
      logic [3:0]           t;
      logic [LW-1:0]        cap;
      b = item.rx_byte;
      t = header_store[1][3:0];
      res = '0;
      if (item.func) begin
         reset_parser();
         rx_expected_seq = '0;
         return;
      end
      if (parse_phase == tw_slip_pkg::PH_HUNT) begin
         if (b == tw_slip_pkg::SLIP_END) begin
            reset_parser();
            parse_phase = tw_slip_pkg::PH_HEADER;
         end
         return;
      end
      if (parse_phase == tw_slip_pkg::PH_END) begin
         if (b != tw_slip_pkg::SLIP_END)
            drop_packet(tw_slip_pkg::ERR_NO_END, 1'b1);
         else if (header_store[0][7] && header_store[0][2:0] != rx_expected_seq)
            drop_packet(tw_slip_pkg::ERR_SEQUENCE, 1'b1);
         else begin
            if (needs_ack(t))
               rx_expected_seq = rx_expected_seq + 3'd1;
            res = with_header(res);
            res.kind = tw_slip_pkg::KIND_DONE;
            res.destination = route_for(t);
            res.send_ack = needs_ack(t);
            res.next_expected_seq = rx_expected_seq;
            expected_results.push_back(res);
            reset_parser();
         end
         return;
      end
      // header or payload: undo the escapes first
      if (escape_armed) begin
         escape_armed = 1'b0;
         if (b == tw_slip_pkg::ESC_CODE_END)
            b = tw_slip_pkg::SLIP_END;
         else if (b == tw_slip_pkg::ESC_CODE_ESC)
            b = tw_slip_pkg::ESC_BYTE;
         else begin
            drop_packet(tw_slip_pkg::ERR_ESCAPE, parse_phase == tw_slip_pkg::PH_PAYLOAD);
            return;
         end
      end else if (b == tw_slip_pkg::SLIP_END) begin
         if (parse_phase == tw_slip_pkg::PH_HEADER)
            header_idx = '0;
         else
            drop_packet(tw_slip_pkg::ERR_EARLY, 1'b1);
         return;
      end else if (b == tw_slip_pkg::ESC_BYTE) begin
         escape_armed = 1'b1;
         return;
      end
      if (parse_phase == tw_slip_pkg::PH_HEADER) begin
         if (header_idx < 3'd3)
            header_store[header_idx[1:0]] = b;
         header_idx = header_idx + 3'd1;
         if (header_idx == 3'd4) begin
            header_idx = '0;
            t = header_store[1][3:0];
            remaining = {header_store[2], header_store[1][7:4]};
            emitted = '0;
            if ((route_for(t) != tw_slip_pkg::DEST_DISCARD || t == tw_slip_pkg::TYPE_ACK)
                && remaining != '0)
               parse_phase = tw_slip_pkg::PH_PAYLOAD;
            else
               parse_phase = tw_slip_pkg::PH_END;
         end
         return;
      end
      cap = (route_for(t) == tw_slip_pkg::DEST_HOST) ? data_limit : link_limit;
      if (emitted >= cap) begin
         drop_packet(tw_slip_pkg::ERR_OVERFLOW, 1'b1);
         return;
      end
      emitted = emitted + 1'b1;
      remaining = remaining - 1'b1;
      if (remaining == '0)
         parse_phase = tw_slip_pkg::PH_END;
      res.kind = tw_slip_pkg::KIND_DATA;
      res.data_byte = b;
      res.next_expected_seq = rx_expected_seq;
      expected_results.push_back(res);
   endtask

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_result(input tw_slip_pkg::rsp_type got);
      tw_slip_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: result transfer with none expected, expected none, actual %h",
                  $time, got);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      check_field("kind", 12'(want.kind), 12'(got.kind));
      check_field("data_byte", 12'(want.data_byte), 12'(got.data_byte));
      check_field("pkt_type", 12'(want.pkt_type), 12'(got.pkt_type));
      check_field("reliable", 12'(want.reliable), 12'(got.reliable));
      check_field("seq_num", 12'(want.seq_num), 12'(got.seq_num));
      check_field("peer_ack", 12'(want.peer_ack), 12'(got.peer_ack));
      check_field("payload_len", want.payload_len, got.payload_len);
      check_field("destination", 12'(want.destination), 12'(got.destination));
      check_field("send_ack", 12'(want.send_ack), 12'(got.send_ack));
      check_field("error_code", 12'(want.error_code), 12'(got.error_code));
      check_field("next_expected_seq", 12'(want.next_expected_seq),
                  12'(got.next_expected_seq));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         data_limit = tw_slip_pkg::DATA_LIMIT_RESET;
         link_limit = tw_slip_pkg::LINK_LIMIT_RESET;
         reset_parser();
         foreach (header_store[i])
            header_store[i] = '0;
         rx_expected_seq = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_result(rsp_data);
         if (csr_write) begin
            case (csr_index)
               tw_slip_pkg::CSR_DATA_LIMIT: data_limit = csr_wdata;
               tw_slip_pkg::CSR_LINK_LIMIT: link_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            deframe_byte(req_data);
      end
      results_pending = expected_results.size();
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Testbench top: feeds UART bytes and resyncs into the deframer and gives the verdict.
module testbench;

   localparam int MAX_CYCLES  = 200000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 78;
   localparam int NUM_PHASES  = 6;

   // Ways a random frame gets damaged on the line.
   typedef enum int {
      FRAME_CLEAN,
      FRAME_BAD_ESCAPE,
      FRAME_NO_END,
      FRAME_EARLY_END,
      FRAME_HEADER_RESTART
   } frame_fault_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   tw_slip_pkg::req_type            req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   tw_slip_pkg::rsp_type            rsp_data;
   logic                            csr_write = 1'b0;
   tw_slip_pkg::csr_index_type      csr_index = tw_slip_pkg::CSR_DATA_LIMIT;
   logic [tw_slip_pkg::LIMIT_W-1:0] csr_wdata = '0;

   int                 fail_count;
   int                 results_pending;
   logic [2:0]         seq_now;

   int                 cycle_count = 0;
   int                 items_sent = 0;
   logic               sender_idles = 1'b1;
   logic               receiver_idles = 1'b1;
   int                 hold_requests = 0;
   int                 holds_served = 0;
   int                 hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   three_wire_uart_slip_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   deframer_checker deframe_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .seq_now         (seq_now)
   );

   // Receiver side. A new hold request (counted up by the stimulus) starts a long
   // hold-off so the single result slot fills and the deframer stalls its input;
   // otherwise stall at random while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         holds_served <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(0, 99) < 11);
      end
   end

   // Watchdog: bail out if the run hangs.
   initial begin
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Offer one transfer and hold it until accepted. Call at a rising edge; return
   // right after the accepting edge with valid still high.
   task automatic send_item(input tw_slip_pkg::req_type item);
      if (sender_idles && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      tw_slip_pkg::req_type item;
      item.func = 1'b0;
      item.rx_byte = b;
      send_item(item);
   endtask

   task automatic send_resync(input logic [7:0] b);
      tw_slip_pkg::req_type item;
      item.func = 1'b1;
      item.rx_byte = b;
      send_item(item);
   endtask

   // Put one content byte on the line, escaping the two reserved codes.
   task automatic send_escaped(input logic [7:0] b);
      if (b == tw_slip_pkg::SLIP_END) begin
         send_byte(tw_slip_pkg::ESC_BYTE);
         send_byte(tw_slip_pkg::ESC_CODE_END);
      end else if (b == tw_slip_pkg::ESC_BYTE) begin
         send_byte(tw_slip_pkg::ESC_BYTE);
         send_byte(tw_slip_pkg::ESC_CODE_ESC);
      end else begin
         send_byte(b);
      end
   endtask

   // Drop valid, wait for every predicted result to drain, then wait on in case the
   // block is still chewing on a byte with no result.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both limits back to back; write enable stays high across the pair.
   task automatic write_limits(input logic [tw_slip_pkg::LIMIT_W-1:0] data_lim,
                               input logic [tw_slip_pkg::LIMIT_W-1:0] link_lim);
      csr_write <= 1'b1;
      csr_index <= tw_slip_pkg::CSR_DATA_LIMIT;
      csr_wdata <= data_lim;
      @(posedge clock);
      csr_index <= tw_slip_pkg::CSR_LINK_LIMIT;
      csr_wdata <= link_lim;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Hand-picked frames under the reset limits: hunt noise, resync, a clean
   // reliable command with both escapes and a header restart, link overflow,
   // missing end on an unknown type, sequence mismatch, early delimiter and a
   // bad escape whose code is a delimiter.
   task automatic run_directed();
      logic [7:0] script [$];
      send_byte(tw_slip_pkg::ESC_BYTE);
      send_resync(8'hFF);
      script = '{8'hC0, 8'hA8, 8'hC0, 8'hA8, 8'h21, 8'h00, 8'hFF,
                 8'hDB, 8'hDC, 8'hDB, 8'hDD, 8'hC0,
                 8'hC0, 8'h00, 8'h4F, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44,
                 8'hC0, 8'h80, 8'h03, 8'h00, 8'h00, 8'h7E,
                 8'hC0, 8'h87, 8'h02, 8'h00, 8'h00, 8'hC0,
                 8'hC0, 8'h00, 8'h1F, 8'h00, 8'h00, 8'hC0,
                 8'hC0, 8'hDB, 8'hC0};
      foreach (script[i])
         send_byte(script[i]);
   endtask

   // One random frame: mostly well formed with random content, sometimes damaged,
   // sometimes preceded by line noise or a resync.
   task automatic send_packet();
      logic [7:0]      body [$];
      logic [7:0]      bad;
      logic [3:0]      t;
      logic [11:0]     len;
      logic [2:0]      seq;
      logic            rel;
      logic            carries;
      frame_fault_type fault;
      int              n_pay;
      int              inject_at;
      int              r;
      if ($urandom_range(0, 99) < 4)
         send_resync(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 15)
         repeat ($urandom_range(1, 2)) send_byte(8'($urandom_range(0, 255)));
      send_byte(tw_slip_pkg::SLIP_END);

      r = int'($urandom_range(0, 99));
      if (r < 15)
         t = tw_slip_pkg::TYPE_CMD;
      else if (r < 30)
         t = tw_slip_pkg::TYPE_ACL;
      else if (r < 42)
         t = tw_slip_pkg::TYPE_ISO;
      else if (r < 54)
         t = tw_slip_pkg::TYPE_ACK;
      else if (r < 66)
         t = tw_slip_pkg::TYPE_LINK;
      else if (r < 76)
         t = tw_slip_pkg::TYPE_EVT;
      else
         t = 4'($urandom_range(0, 15));
      carries = (t == tw_slip_pkg::TYPE_ACK || t == tw_slip_pkg::TYPE_CMD ||
                 t == tw_slip_pkg::TYPE_ACL || t == tw_slip_pkg::TYPE_ISO ||
                 t == tw_slip_pkg::TYPE_LINK);
      if (t == tw_slip_pkg::TYPE_CMD || t == tw_slip_pkg::TYPE_ACL ||
          t == tw_slip_pkg::TYPE_EVT || t == tw_slip_pkg::TYPE_ISO)
         rel = ($urandom_range(0, 99) < 90);
      else
         rel = 1'($urandom_range(0, 1));
      // Match the sequence the deframer expects most of the time.
      seq = ($urandom_range(0, 99) < 85) ? seq_now : 3'($urandom_range(0, 7));
      r = int'($urandom_range(0, 99));
      if (r < 65)
         len = 12'($urandom_range(0, 8));
      else if (r < 88)
         len = 12'($urandom_range(9, 40));
      else
         len = 12'($urandom_range(0, 4095));

      body.push_back({rel, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), seq});
      body.push_back({len[3:0], t});
      body.push_back(len[11:4]);
      body.push_back(8'($urandom_range(0, 255)));
      // Cap long payloads; the closing delimiter then lands early.
      n_pay = carries ? ((len > 48) ? 48 : int'(len)) : 0;

      r = int'($urandom_range(0, 99));
      if (r < 6)
         fault = FRAME_BAD_ESCAPE;
      else if (r < 11)
         fault = FRAME_NO_END;
      else if (r < 15)
         fault = FRAME_EARLY_END;
      else if (r < 19)
         fault = FRAME_HEADER_RESTART;
      else
         fault = FRAME_CLEAN;
      if (fault == FRAME_EARLY_END && n_pay > 0)
         n_pay = int'($urandom_range(0, n_pay - 1));

      repeat (n_pay) begin
         if ($urandom_range(0, 99) < 12)
            body.push_back($urandom_range(0, 1) ? tw_slip_pkg::SLIP_END
                                                : tw_slip_pkg::ESC_BYTE);
         else
            body.push_back(8'($urandom_range(0, 255)));
      end

      if (fault == FRAME_HEADER_RESTART) begin
         repeat ($urandom_range(1, 3)) send_escaped(8'($urandom_range(0, 255)));
         send_byte(tw_slip_pkg::SLIP_END);
      end

      inject_at = int'($urandom_range(0, body.size() - 1));
      bad = 8'($urandom_range(0, 255));
      if (bad == tw_slip_pkg::ESC_CODE_END || bad == tw_slip_pkg::ESC_CODE_ESC)
         bad = tw_slip_pkg::SLIP_END;
      foreach (body[i]) begin
         if (fault == FRAME_BAD_ESCAPE && i == inject_at) begin
            send_byte(tw_slip_pkg::ESC_BYTE);
            send_byte(bad);
         end
         send_escaped(body[i]);
      end

      if (fault == FRAME_NO_END) begin
         bad = 8'($urandom_range(0, 255));
         if (bad == tw_slip_pkg::SLIP_END)
            bad = 8'h00;
         send_byte(bad);
      end else begin
         send_byte(tw_slip_pkg::SLIP_END);
      end
   endtask

   // Main stimulus: reset, directed frames, then random phases each under its own
   // pair of limits (extremes included), with one long receiver hold-off and one
   // stretch with no idling on either side.
   initial begin
      int phase_goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            1: write_limits(12'd0, 12'd0);
            2: write_limits(12'd4095, 12'd4095);
            3: write_limits(12'($urandom_range(1, 24)), 12'($urandom_range(0, 6)));
            4: write_limits(12'd1, 12'd4095);
            5: write_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 8)));
            default: ;
         endcase
         sender_idles = (phase != 3);
         receiver_idles <= (phase != 3);
         if (phase == 2)
            hold_requests <= hold_requests + 1;
         phase_goal = items_sent + PHASE_ITEMS;
         while (items_sent < phase_goal)
            send_packet();
      end
      wait_idle();
      // Sample the failure count away from the clock edge.
      @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
